FILE: rtl/core/fms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fms_pkg;

    // default population capacity
    localparam int unsigned POPULATION_SIZE_DEF = 32;

    // apb address and data widths and the paddr[2] value that selects the order register
    localparam int unsigned APB_AW       = 3;
    localparam int unsigned APB_DW       = 32;
    localparam logic        REG_SORT_ASC = 1'b0;

    // one accepted transaction on the input side
    typedef struct packed {
        logic signed [31:0] fitness_key;
        logic        [4:0]  member_tag;
        logic               last_member;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic signed [31:0] sorted_key;
        logic        [4:0]  sorted_tag;
        logic               run_end;
        logic               overflowed;
    } t_result;

    // content of one cell of the chain
    typedef struct packed {
        logic               valid;
        logic signed [31:0] key;
        logic        [4:0]  tag;
    } t_entry;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic swap_r;
        logic swap_l;
    } t_cell_ctl;

    // sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_DRAIN
    } t_state;

    // true if key a must come strictly before key b
    function automatic logic goes_before(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic               asc
    );
        logic res;
        res = asc ? (a < b) : (a > b);
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fitness_merge_sorter.sv
`timescale 1ns / 1ps
`default_nettype none

// Stable fitness sorter for one population of up to POPULATION_SIZE members.
// Members are taken one per cycle while busy is low; each is stored in the
// next free cell of a chain of cells, and members beyond capacity are dropped
// and reported on the overflowed bit of every result of that run. The member
// with last_member set starts the run: busy rises for n phases of odd-even
// exchange between neighboring cells (n = stored members, at least one),
// followed by a drain in which the chain shifts one rank per cycle toward
// cell 0. Each result is registered from cell 0 as it shifts, one per cycle,
// and is present on the result ports for exactly one cycle with o_result_valid
// high; the receiver cannot stall them and must take every one. run_end marks
// the last. The order register (byte address 0) selects highest fitness first
// (0) or lowest first (1); equal keys keep arrival order. Write it only while
// no run is in progress.
module fitness_merge_sorter #(
    parameter int unsigned POPULATION_SIZE = fms_pkg::POPULATION_SIZE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // item channel
    input  wire logic                        start,
    output logic                             busy,
    input  wire fms_pkg::t_item              i_item,
    // result channel
    output logic                             o_result_valid,
    output fms_pkg::t_result                 o_result,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fms_pkg::APB_AW-1:0]  paddr,
    input  wire logic [fms_pkg::APB_DW-1:0]  pwdata,
    output logic      [fms_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    localparam int unsigned CW = $clog2(POPULATION_SIZE + 1);

    fms_pkg::t_state  r_state;
    fms_pkg::t_state  n_state;
    logic [CW-1:0]    r_fill;
    logic [CW-1:0]    n_fill;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_asc;
    logic             r_res_valid;
    logic             n_res_valid;
    fms_pkg::t_result r_result;
    fms_pkg::t_result n_result;

    logic             accept;
    logic             sorting;
    logic             draining;
    fms_pkg::t_entry  load_entry;
    fms_pkg::t_entry  zero_entry;

    fms_pkg::t_entry    w_cell [POPULATION_SIZE];
    fms_pkg::t_cell_ctl w_ctl  [POPULATION_SIZE];
    logic [POPULATION_SIZE-1:0] w_swap;

    // apb register access
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asc <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == fms_pkg::REG_SORT_ASC) begin
            r_asc <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == fms_pkg::REG_SORT_ASC) begin
            prdata[0] = r_asc;
        end
    end

    // handshake
    assign busy     = (r_state != fms_pkg::ST_LOAD);
    assign accept   = start && !busy;
    assign sorting  = (r_state == fms_pkg::ST_SORT);
    assign draining = (r_state == fms_pkg::ST_DRAIN);

    assign load_entry.valid = 1'b1;
    assign load_entry.key   = i_item.fitness_key;
    assign load_entry.tag   = i_item.member_tag;
    assign zero_entry       = '0;

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fms_pkg::ST_LOAD;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // next state, counters and result register
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_res_valid = 1'b0;
        n_result    = r_result;
        unique case (r_state)
            fms_pkg::ST_LOAD: begin
                if (accept) begin
                    if (r_fill < CW'(POPULATION_SIZE)) begin
                        n_fill = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last_member) begin
                        n_state = fms_pkg::ST_SORT;
                        n_cnt   = '0;
                    end
                end
            end
            fms_pkg::ST_SORT: begin
                // n exchange phases sort n members
                if (r_cnt == r_fill - CW'(1)) begin
                    n_state = fms_pkg::ST_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            fms_pkg::ST_DRAIN: begin
                n_res_valid         = 1'b1;
                n_result.sorted_key = w_cell[0].key;
                n_result.sorted_tag = w_cell[0].tag;
                n_result.overflowed = r_ovf;
                n_result.run_end    = (r_cnt == r_fill - CW'(1));
                if (r_cnt == r_fill - CW'(1)) begin
                    n_state = fms_pkg::ST_LOAD;
                    n_fill  = '0;
                    n_ovf   = 1'b0;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            default: begin
                n_state = fms_pkg::ST_LOAD;
            end
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

    // chain of cells with a compare element on each boundary
    for (genvar i = 0; i < POPULATION_SIZE; i++) begin : g_chain
        fms_pkg::t_entry w_right;
        fms_pkg::t_entry w_left;

        if (i == POPULATION_SIZE - 1) begin : g_tail
            assign w_right   = zero_entry;
            assign w_swap[i] = 1'b0;
        end else begin : g_body
            assign w_right = w_cell[i+1];
            fms_cmp u_cmp (
                .i_en    (sorting && (r_cnt[0] == 1'(i % 2))),
                .i_asc   (r_asc),
                .i_left  (w_cell[i]),
                .i_right (w_cell[i+1]),
                .o_swap  (w_swap[i])
            );
        end

        if (i == 0) begin : g_head
            assign w_left         = zero_entry;
            assign w_ctl[i].swap_l = 1'b0;
        end else begin : g_inner
            assign w_left          = w_cell[i-1];
            assign w_ctl[i].swap_l = w_swap[i-1];
        end

        assign w_ctl[i].load   = accept && (r_fill == CW'(i));
        assign w_ctl[i].shift  = draining;
        assign w_ctl[i].swap_r = w_swap[i];

        fms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[i]),
            .i_load  (load_entry),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_cell[i])
        );
    end

endmodule

`default_nettype wire

FILE: rtl/core/fms_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module fms_cmp (
    input  wire logic             i_en,
    input  wire logic             i_asc,
    input  wire fms_pkg::t_entry  i_left,
    input  wire fms_pkg::t_entry  i_right,
    output logic                  o_swap
);

    // swap only on strict misorder so equal keys keep arrival order
    always_comb begin
        o_swap = i_en && i_left.valid && i_right.valid
                 && fms_pkg::goes_before(i_right.key, i_left.key, i_asc);
    end

endmodule

`default_nettype wire

FILE: rtl/core/fms_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module fms_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fms_pkg::t_cell_ctl i_ctl,
    input  wire fms_pkg::t_entry    i_load,
    input  wire fms_pkg::t_entry    i_left,
    input  wire fms_pkg::t_entry    i_right,
    output fms_pkg::t_entry         o_entry
);

    fms_pkg::t_entry r_entry;
    fms_pkg::t_entry n_entry;

    // next content: load, drain shift, or exchange with a neighbor
    always_comb begin
        priority if (i_ctl.load) begin
            n_entry = i_load;
        end else if (i_ctl.shift || i_ctl.swap_r) begin
            n_entry = i_right;
        end else if (i_ctl.swap_l) begin
            n_entry = i_left;
        end else begin
            n_entry = r_entry;
        end
    end

    // valid bit is control state, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.key <= n_entry.key;
        r_entry.tag <= n_entry.tag;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire
